// ===== hw/rtl/hnv_pkg.sv =====
// Package for the HTTP name[=value] parser: types, codes and character classes.
package hnv_pkg;

  // Output part codes
  typedef enum logic [1:0] {
    PART_NAME  = 2'd0,
    PART_VALUE = 2'd1,
    PART_LEFT  = 2'd2,
    PART_SUM   = 2'd3
  } part_t;

  // Parse phases
  typedef enum logic [2:0] {
    PH_NAME   = 3'd0,
    PH_GAP1   = 3'd1,
    PH_GAP2   = 3'd2,
    PH_TOKEN  = 3'd3,
    PH_QUOTED = 3'd4,
    PH_ESCAPE = 3'd5,
    PH_REST   = 3'd6
  } phase_t;

  // Special bytes
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_EQUAL     = 8'h3d;

  // Result queue depth (must be at least 2)
  localparam int RES_FIFO_DEPTH = 4;

  // Parser state carried between items
  typedef struct packed {
    phase_t phase;
    logic   name_seen;
    logic   value_seen;
    logic   quoted_seen;
  } parse_state_t;

  // One result item
  typedef struct packed {
    part_t      part;
    logic [7:0] out_byte;
    logic       value_present;
    logic       value_quoted;
    logic       last;
  } result_t;

  // What one input item produces
  typedef struct packed {
    logic         byte_vld;
    result_t      byte_res;
    logic         sum_vld;
    result_t      sum_res;
    parse_state_t state_nxt;
  } step_out_t;

  // Control bytes: 0..31 and DEL
  function automatic logic is_ctl(input logic [7:0] c);
    is_ctl = (c <= 8'd31) || (c == 8'h7f);
  endfunction

  // Separator characters of the HTTP token grammar
  function automatic logic is_separator(input logic [7:0] c);
    logic sep;
    sep = 1'b0;
    case (c)
      8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
      8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09: sep = 1'b1;
      default: sep = 1'b0;
    endcase
    is_separator = sep;
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    is_token = !c[7] && !is_ctl(c) && !is_separator(c);
  endfunction

  // Whitespace is anything up to and including space
  function automatic logic is_space(input logic [7:0] c);
    is_space = (c <= 8'h20);
  endfunction

endpackage

// ===== hw/rtl/hnv_if.sv =====
// Valid/ready channel interfaces for parser input bytes and result items.
interface hnv_in_if;
  import hnv_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface hnv_out_if;
  import hnv_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] part;
  logic [7:0] out_byte;
  logic       value_present;
  logic       value_quoted;
  logic       last;

  modport source (output valid, output part, output out_byte, output value_present,
                  output value_quoted, output last, input ready);
  modport sink   (input valid, input part, input out_byte, input value_present,
                  input value_quoted, input last, output ready);
endinterface

// ===== hw/rtl/hnv_step.sv =====
// Combinational parse step: one byte against the current state.
module hnv_step
  import hnv_pkg::*;
(
  input  parse_state_t state,
  input  logic [7:0]   data_byte,
  input  logic         end_of_input,
  output step_out_t    step
);

  phase_t phase_nxt;
  logic   name_nxt;
  logic   value_nxt;
  logic   quoted_nxt;
  logic   emit;
  part_t  part;

  // Phase transitions and byte classification
  always_comb begin
    phase_nxt  = state.phase;
    name_nxt   = state.name_seen;
    value_nxt  = state.value_seen;
    quoted_nxt = state.quoted_seen;
    emit       = 1'b0;
    part       = PART_LEFT;
    unique case (state.phase)
      PH_NAME, PH_GAP1: begin
        if (state.phase == PH_NAME && is_token(data_byte)) begin
          name_nxt = 1'b1;
          emit     = 1'b1;
          part     = PART_NAME;
        end else if (state.phase == PH_NAME && !state.name_seen) begin
          phase_nxt = PH_REST;
          emit      = 1'b1;
        end else if (is_space(data_byte)) begin
          phase_nxt = PH_GAP1;
        end else if (data_byte == CH_EQUAL) begin
          value_nxt = 1'b1;
          phase_nxt = PH_GAP2;
        end else begin
          phase_nxt = PH_REST;
          emit      = 1'b1;
        end
      end
      PH_GAP2, PH_TOKEN: begin
        if (state.phase == PH_GAP2 && is_space(data_byte)) begin
          phase_nxt = PH_GAP2;
        end else if (state.phase == PH_GAP2 && data_byte == CH_QUOTE) begin
          quoted_nxt = 1'b1;
          phase_nxt  = PH_QUOTED;
        end else if (is_token(data_byte)) begin
          phase_nxt = PH_TOKEN;
          emit      = 1'b1;
          part      = PART_VALUE;
        end else begin
          phase_nxt = PH_REST;
          emit      = 1'b1;
        end
      end
      PH_QUOTED: begin
        if (data_byte == CH_BACKSLASH) begin
          phase_nxt = PH_ESCAPE;
        end else if (data_byte == CH_QUOTE) begin
          phase_nxt = PH_REST;
        end else if (!is_ctl(data_byte)) begin
          emit = 1'b1;
          part = PART_VALUE;
        end
      end
      PH_ESCAPE: begin
        phase_nxt = PH_QUOTED;
        emit      = 1'b1;
        part      = PART_VALUE;
      end
      default: begin
        // leftover phase, and any code with no meaning
        phase_nxt = PH_REST;
        emit      = 1'b1;
      end
    endcase
  end

  // Results and next state; end of text returns to reset state
  always_comb begin
    step.byte_vld               = emit;
    step.byte_res.part          = part;
    step.byte_res.out_byte      = data_byte;
    step.byte_res.value_present = 1'b0;
    step.byte_res.value_quoted  = 1'b0;
    step.byte_res.last          = 1'b0;

    step.sum_vld                = end_of_input;
    step.sum_res.part           = PART_SUM;
    step.sum_res.out_byte       = 8'h00;
    step.sum_res.value_present  = value_nxt;
    step.sum_res.value_quoted   = quoted_nxt;
    step.sum_res.last           = 1'b1;

    if (end_of_input) begin
      step.state_nxt.phase       = PH_NAME;
      step.state_nxt.name_seen   = 1'b0;
      step.state_nxt.value_seen  = 1'b0;
      step.state_nxt.quoted_seen = 1'b0;
    end else begin
      step.state_nxt.phase       = phase_nxt;
      step.state_nxt.name_seen   = name_nxt;
      step.state_nxt.value_seen  = value_nxt;
      step.state_nxt.quoted_seen = quoted_nxt;
    end
  end

endmodule

// ===== hw/rtl/http_name_value_parser_top.sv =====
// Top level of the HTTP name[=value] parser with its result queue.
//
// Parses one name[=value] pair per text from a byte stream and emits each
// name, value and leftover byte as a tagged item, followed by a summary item
// after the byte flagged end_of_input. One byte is accepted per cycle while
// the queue has room; the parse step is short logic from the input port into a
// small result queue, which holds up to FIFO_DEPTH results. A byte that ends a
// text can produce two results (its byte and the summary), which leave the
// queue one at a time. Input is taken while the queue has room for two results,
// independent of whether the sink is currently taking the oldest one.
module http_name_value_parser_top
  import hnv_pkg::*;
#(
  parameter int FIFO_DEPTH = RES_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  hnv_in_if.sink      in_ch,
  hnv_out_if.source   out_ch
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  parse_state_t     state_r;
  step_out_t        step;
  result_t          fifo_mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_1;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             in_fire, out_fire;
  logic [1:0]       push_n;
  result_t          first_res;

  hnv_step u_step (
    .state        (state_r),
    .data_byte    (in_ch.data_byte),
    .end_of_input (in_ch.end_of_input),
    .step         (step)
  );

  // Handshakes
  assign in_ch.ready = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (count_r != '0);
  assign out_fire    = out_ch.valid && out_ch.ready;

  // Head of queue drives the result channel
  assign out_ch.part          = fifo_mem_r[rd_ptr_r].part;
  assign out_ch.out_byte      = fifo_mem_r[rd_ptr_r].out_byte;
  assign out_ch.value_present = fifo_mem_r[rd_ptr_r].value_present;
  assign out_ch.value_quoted  = fifo_mem_r[rd_ptr_r].value_quoted;
  assign out_ch.last          = fifo_mem_r[rd_ptr_r].last;

  // Queue pointer and count updates
  always_comb begin
    push_n    = 2'd0;
    first_res = step.byte_vld ? step.byte_res : step.sum_res;
    if (in_fire) begin
      push_n = {1'b0, step.byte_vld} + {1'b0, step.sum_vld};
    end
    wr_ptr_1   = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    wr_ptr_nxt = wr_ptr_r;
    if (push_n == 2'd1) begin
      wr_ptr_nxt = wr_ptr_1;
    end else if (push_n == 2'd2) begin
      wr_ptr_nxt = (wr_ptr_1 == PTR_LAST) ? '0 : wr_ptr_1 + PTR_W'(1);
    end
    rd_ptr_nxt = rd_ptr_r;
    if (out_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(push_n) - CNT_W'(out_fire);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_NAME;
      state_r.name_seen   <= 1'b0;
      state_r.value_seen  <= 1'b0;
      state_r.quoted_seen <= 1'b0;
      wr_ptr_r            <= '0;
      rd_ptr_r            <= '0;
      count_r             <= '0;
    end else begin
      if (in_fire) begin
        state_r <= step.state_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Result storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem_r[wr_ptr_r] <= first_res;
    end
    if (push_n == 2'd2) begin
      fifo_mem_r[wr_ptr_1] <= step.sum_res;
    end
  end

endmodule

// ===== test/hnv_parse_checker.sv =====
`timescale 1ns / 1ps
// Channel monitor for the name[=value] parser: predicts tagged bytes and summaries, compares.
module hnv_parse_checker
  import hnv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  hnv_in_if    in_ch,
  hnv_out_if   out_ch,
  output int   fail_count,
  output int   pending_count
);

  // Predicted parser state
  phase_t  phase;
  logic    name_seen;
  logic    value_seen;
  logic    quoted_seen;

  // Tagged bytes and summaries still to come out, oldest first
  result_t parsed_due[$];
  int      bad_results = 0;

  // Character classes of the header grammar
  function automatic logic ctl_char(input logic [7:0] c);
    return (c < 8'd32) || (c == 8'd127);
  endfunction

  function automatic logic sep_char(input logic [7:0] c);
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=",
      "{", "}", " ", "\t": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic token_char(input logic [7:0] c);
    return (c < 8'd128) && !ctl_char(c) && !sep_char(c);
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return c <= 8'd32;
  endfunction

  // Advance the predicted parse by one byte and queue what it produces
  function automatic void parse_byte(input logic [7:0] c, input logic eoi);
    logic    done;
    logic    emit;
    part_t   tag;
    result_t r;
    done = 1'b0;
    emit = 1'b0;
    tag  = PART_LEFT;

    // name run; a non-token byte ends it
    if (phase == PH_NAME) begin
      if (token_char(c)) begin
        name_seen = 1'b1;
        done      = 1'b1;
        emit      = 1'b1;
        tag       = PART_NAME;
      end else begin
        phase = name_seen ? PH_GAP1 : PH_REST;
      end
    end

    // blanks around '=', quoted string and escapes
    if (!done) begin
      case (phase)
        PH_GAP1: begin
          if (blank_char(c)) begin
            done = 1'b1;
          end else if (c == CH_EQUAL) begin
            value_seen = 1'b1;
            phase      = PH_GAP2;
            done       = 1'b1;
          end else begin
            phase = PH_REST;
          end
        end
        PH_GAP2: begin
          if (blank_char(c)) begin
            done = 1'b1;
          end else if (c == CH_QUOTE) begin
            quoted_seen = 1'b1;
            phase       = PH_QUOTED;
            done        = 1'b1;
          end else begin
            phase = PH_TOKEN;
          end
        end
        PH_QUOTED: begin
          done = 1'b1;
          if (c == CH_BACKSLASH) begin
            phase = PH_ESCAPE;
          end else if (c == CH_QUOTE) begin
            phase = PH_REST;
          end else if (!ctl_char(c)) begin
            emit = 1'b1;
            tag  = PART_VALUE;
          end
        end
        PH_ESCAPE: begin
          // escaped byte is taken as is, even a control
          phase = PH_QUOTED;
          done  = 1'b1;
          emit  = 1'b1;
          tag   = PART_VALUE;
        end
        default: ;
      endcase
    end

    // token value
    if (!done && phase == PH_TOKEN) begin
      if (token_char(c)) begin
        done = 1'b1;
        emit = 1'b1;
        tag  = PART_VALUE;
      end else begin
        phase = PH_REST;
      end
    end

    // anything not consumed is leftover
    if (!done) emit = 1'b1;

    if (emit) begin
      r          = '0;
      r.part     = tag;
      r.out_byte = c;
      parsed_due.push_back(r);
    end

    // summary closes the text and restarts the parse
    if (eoi) begin
      r               = '0;
      r.part          = PART_SUM;
      r.value_present = value_seen;
      r.value_quoted  = quoted_seen;
      r.last          = 1'b1;
      parsed_due.push_back(r);
      phase       = PH_NAME;
      name_seen   = 1'b0;
      value_seen  = 1'b0;
      quoted_seen = 1'b0;
    end
  endfunction

  // Compare one output item with the oldest prediction
  task automatic check_result();
    result_t got;
    result_t want;
    got.part          = part_t'(out_ch.part);
    got.out_byte      = out_ch.out_byte;
    got.value_present = out_ch.value_present;
    got.value_quoted  = out_ch.value_quoted;
    got.last          = out_ch.last;
    if (parsed_due.size() == 0) begin
      bad_results++;
      if (bad_results <= 10)
        $display("unexpected item: part %0d byte %02h vp %0b vq %0b last %0b",
                 got.part, got.out_byte, got.value_present, got.value_quoted, got.last);
    end else begin
      // take the oldest prediction off the queue
      want = parsed_due[0];
      parsed_due.delete(0);
      if (got.part !== want.part || got.out_byte !== want.out_byte ||
          got.value_present !== want.value_present ||
          got.value_quoted !== want.value_quoted || got.last !== want.last) begin
        bad_results++;
        if (bad_results <= 10)
          $display("item mismatch: expected part %0d byte %02h vp %0b vq %0b last %0b, %s",
                   want.part, want.out_byte, want.value_present, want.value_quoted,
                   want.last, $sformatf("got part %0d byte %02h vp %0b vq %0b last %0b",
                   got.part, got.out_byte, got.value_present, got.value_quoted, got.last));
      end
    end
  endtask

  // Sample both channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      phase       = PH_NAME;
      name_seen   = 1'b0;
      value_seen  = 1'b0;
      quoted_seen = 1'b0;
      parsed_due.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.data_byte, in_ch.end_of_input);
      if (out_ch.valid && out_ch.ready) check_result();
    end
    fail_count    <= bad_results;
    pending_count <= parsed_due.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the parser testbench: clock, reset, header text stimulus, receiver and verdict.
module testbench;
  import hnv_pkg::*;

  localparam string TOKEN_CHARS = "abcmxyzAMZ0579!#$%&'*+-.^_`|~";

  logic       clk;
  logic       rst_n;
  int         fail_count;
  int         pending_count;
  int         gap_pct;
  int         stall_pct;
  bit         hold_req;
  int         items_sent;
  logic [7:0] text_q[$];

  hnv_in_if  in_ch();
  hnv_out_if out_ch();

  http_name_value_parser_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hnv_parse_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one byte, idling a random number of cycles first, and wait for acceptance
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Send the queued text, flagging its final byte
  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    items_sent += text_q.size();
    text_q.delete();
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic add_blank();
    text_q.push_back(8'($urandom_range(0, 32)));
  endtask

  task automatic add_token();
    text_q.push_back(TOKEN_CHARS[$urandom_range(TOKEN_CHARS.len() - 1)]);
  endtask

  // Mostly well-formed name[=value] texts with random content, some noise
  task automatic build_random_text();
    int roll;
    int cut;
    roll = $urandom_range(99);
    text_q.delete();
    if (roll < 12) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
    end else begin
      // name, now and then empty
      repeat ($urandom_range((roll < 20) ? 0 : 1, 4)) add_token();
      if ($urandom_range(99) < 30) add_blank();
      if ($urandom_range(99) < 80) begin
        text_q.push_back(CH_EQUAL);
        if ($urandom_range(99) < 30) add_blank();
        if ($urandom_range(99) < 45) begin
          repeat ($urandom_range(0, 4)) add_token();
        end else begin
          text_q.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(3))
              0: text_q.push_back(8'($urandom_range(32, 126)));
              1: begin
                text_q.push_back(CH_BACKSLASH);
                text_q.push_back(8'($urandom_range(255)));
              end
              2: text_q.push_back(8'($urandom_range(0, 31)));
              default: text_q.push_back(8'($urandom_range(127, 255)));
            endcase
          end
          if ($urandom_range(99) < 85) text_q.push_back(CH_QUOTE);
        end
      end
      // trailing leftover
      if ($urandom_range(99) < 35)
        repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(255)));
      // broken text: cut short
      if (text_q.size() > 1 && $urandom_range(99) < 12) begin
        cut = $urandom_range(1, text_q.size() - 1);
        while (text_q.size() > cut) void'(text_q.pop_back());
      end
    end
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic run_random(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      build_random_text();
      send_text();
    end
  endtask

  // Receiver: random stalls, and one long hold-off on request
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.data_byte    <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    out_ch.ready       <= 1'b0;
    rst_n              <= 1'b0;
    gap_pct    = 23;
    stall_pct  = 23;
    hold_req   = 1'b0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // one-byte name
    add_str("x");
    send_text();
    // empty name: quote first, all leftover
    add_str("\"q");
    send_text();
    // blanks around '=', quoted value with escaped control, dropped DEL, high byte
    add_str("n \t=");
    text_q.push_back(8'h00);
    add_str("\"a\\");
    text_q.push_back(8'h01);
    text_q.push_back(8'h7f);
    text_q.push_back(8'hff);
    add_str("\"z");
    send_text();
    // no '=': rest is leftover
    add_str("k;");
    send_text();
    // empty value
    add_str("v=;");
    send_text();
    // dangling backslash in an unterminated string
    add_str("t=\"\\");
    send_text();
    // top byte as empty name
    text_q.push_back(8'hff);
    send_text();

    run_random(150);

    // receiver holds off while bytes keep coming
    gap_pct  = 0;
    hold_req = 1'b1;
    run_random(40);

    // long stretch with no idling on either side
    stall_pct = 0;
    run_random(100);

    gap_pct   = 23;
    stall_pct = 23;
    run_random(120);
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
